// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge outside reset
`ifndef SYNTH
`define ASSERT_ON(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_ON(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ===== hdl/wcsg_pkg.sv =====
package wcsg_pkg;

   localparam int LED_COUNT    = 6;
   localparam int WHEEL_STEPS  = 256;
   localparam int FADE_STEPS   = 314;
   localparam int RAINBOW_COLS = 6;
   localparam int DIV_STAGES   = 4;
   localparam int DIV_STEPS    = 8;
   localparam int BRIGHT_W     = 17;
   localparam int LAST_LED     = LED_COUNT - 1;
   localparam int IDX_W        = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int HALF_GROUP   = (LED_COUNT / 2 > 0) ? LED_COUNT / 2 : 1;
   localparam int GCNT_W       = (HALF_GROUP > 1) ? $clog2(HALF_GROUP) : 1;
   localparam logic [7:0] STEP_HALF  = 8'((WHEEL_STEPS / 2) % 256);
   localparam logic [7:0] STEP_SIXTH = 8'((WHEEL_STEPS / 6) % 256);
   localparam logic [BRIGHT_W-1:0] BRIGHT_ONE = BRIGHT_W'(65536);

   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   typedef enum logic [1:0] {
      TIMING_SYNCED, TIMING_STAGGERED, TIMING_LOCAL, TIMING_ALTERNATE
   } timing_mode_type;

   typedef enum logic [1:0] {
      STRIPE_SOLID, STRIPE_CANDY, STRIPE_HALF, STRIPE_RAINBOW
   } inside_mode_type;

   typedef enum logic [2:0] {
      REG_PATTERN_SPEED, REG_FADE_SPEED, REG_FADE_SYNCED, REG_BRIGHTNESS,
      REG_TIMING_MODE, REG_INSIDE_MODE, REG_OWN_ADDRESS, REG_NODE_COUNT
   } reg_index_type;

   typedef struct packed {
      logic [7:0]      pattern_speed;
      logic [7:0]      fade_speed;
      logic            fade_synced;
      logic [7:0]      brightness_scale;
      timing_mode_type timing_mode;
      inside_mode_type inside_mode;
      logic [7:0]      own_address;
      logic [7:0]      node_count;
   } cfg_type;

   typedef struct packed {
      logic [31:0] num_w;
      logic [31:0] num_f;
      logic [7:0]  rem_w;
      logic [7:0]  rem_f;
      logic [7:0]  q_w;
      logic [8:0]  q_f;
   } div_type;

   typedef logic [BRIGHT_W-1:0] fade_rom_type  [FADE_STEPS];
   typedef logic [BRIGHT_W-1:0] scale_rom_type [256];
   typedef logic [8:0]          step_rom_type  [256];

   // long division for building the constant tables
   function automatic logic [63:0] table_udiv(logic [63:0] dividend, logic [63:0] divisor);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], dividend[b]};
         if (rem >= {1'b0, divisor}) begin
            rem = rem - {1'b0, divisor};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [BRIGHT_W-1:0] fade_entry(int idx);
      logic [63:0]        x;
      logic [63:0]        y;
      logic [63:0]        y2;
      logic [63:0]        term;
      logic [63:0]        num;
      logic signed [63:0] sum;
      logic               neg;
      x = (64'(idx) << 30) / 64'd50;
      if (x > PI_Q30) x = 64'd2 * PI_Q30 - x;
      if (x > HALF_PI_Q30) begin
         y = PI_Q30 - x;
         neg = 1'b1;
      end else begin
         y = x;
         neg = 1'b0;
      end
      y2 = (y * y) >> 30;
      term = ONE_Q30;
      sum = signed'(ONE_Q30);
      for (int k = 1; k <= 10; k++) begin
         term = table_udiv((term * y2) >> 30, 64'((2 * k - 1) * (2 * k)));
         if (k % 2 == 1) sum = sum - signed'(term);
         else sum = sum + signed'(term);
      end
      if (sum > signed'(ONE_Q30)) sum = signed'(ONE_Q30);
      if (sum < 0) sum = 0;
      if (neg) sum = -sum;
      num = unsigned'(64'sd2 * sum + 64'sd3 * signed'(ONE_Q30));
      return BRIGHT_W'(num / 64'd81920);
   endfunction

   function automatic fade_rom_type build_fade_rom();
      fade_rom_type rom;
      for (int i = 0; i < FADE_STEPS; i++) rom[i] = fade_entry(i);
      return rom;
   endfunction

   function automatic scale_rom_type build_scale_rom();
      scale_rom_type rom;
      for (int b = 0; b < 256; b++) rom[b] = BRIGHT_W'(((200 + b * 800 / 255) * 65536) / 1000);
      return rom;
   endfunction

   function automatic step_rom_type build_step_rom();
      step_rom_type rom;
      rom[0] = 9'(WHEEL_STEPS);
      for (int n = 1; n < 256; n++) rom[n] = 9'(table_udiv(64'(WHEEL_STEPS), 64'(n)));
      return rom;
   endfunction

   localparam fade_rom_type  FADE_ROM  = build_fade_rom();
   localparam scale_rom_type SCALE_ROM = build_scale_rom();
   localparam step_rom_type  STEP_ROM  = build_step_rom();

endpackage

// ===== hdl/wcsg_csr.sv =====
module wcsg_csr
   import wcsg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write;

   assign index = reg_index_type'(csr_paddr[4:2]);
   assign write = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_PATTERN_SPEED: cfg_in.pattern_speed = csr_pwdata[7:0];
            REG_FADE_SPEED:    cfg_in.fade_speed = csr_pwdata[7:0];
            REG_FADE_SYNCED:   cfg_in.fade_synced = csr_pwdata[0];
            REG_BRIGHTNESS:    cfg_in.brightness_scale = csr_pwdata[7:0];
            REG_TIMING_MODE:   cfg_in.timing_mode = timing_mode_type'(csr_pwdata[1:0]);
            REG_INSIDE_MODE:   cfg_in.inside_mode = inside_mode_type'(csr_pwdata[1:0]);
            REG_OWN_ADDRESS:   cfg_in.own_address = csr_pwdata[7:0];
            REG_NODE_COUNT:    cfg_in.node_count = csr_pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_PATTERN_SPEED: csr_prdata = {24'd0, cfg_ff.pattern_speed};
         REG_FADE_SPEED:    csr_prdata = {24'd0, cfg_ff.fade_speed};
         REG_FADE_SYNCED:   csr_prdata = {31'd0, cfg_ff.fade_synced};
         REG_BRIGHTNESS:    csr_prdata = {24'd0, cfg_ff.brightness_scale};
         REG_TIMING_MODE:   csr_prdata = {30'd0, cfg_ff.timing_mode};
         REG_INSIDE_MODE:   csr_prdata = {30'd0, cfg_ff.inside_mode};
         REG_OWN_ADDRESS:   csr_prdata = {24'd0, cfg_ff.own_address};
         REG_NODE_COUNT:    csr_prdata = {24'd0, cfg_ff.node_count};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_speed    <= 8'd42;
         cfg_ff.fade_speed       <= 8'd0;
         cfg_ff.fade_synced      <= 1'b0;
         cfg_ff.brightness_scale <= 8'd255;
         cfg_ff.timing_mode      <= TIMING_SYNCED;
         cfg_ff.inside_mode      <= STRIPE_SOLID;
         cfg_ff.own_address      <= 8'd0;
         cfg_ff.node_count       <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/wcsg_div_stage.sv =====
module wcsg_div_stage
   import wcsg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       valid_in,
   input  div_type    d_in,
   input  logic [7:0] ps,
   input  logic [7:0] fs,
   output logic       valid_out,
   output div_type    d_out
);

   div_type    d_ff;
   div_type    d_in_next;
   logic       valid_ff;
   div_type    cur;
   logic [8:0] rw;
   logic [8:0] rf;
   logic [8:0] qw;
   logic [9:0] qf;
   logic       bit_w;
   logic       bit_f;

   // eight restoring steps per lane, quotient kept modulo wheel and fade length
   always_comb begin
      cur = d_in;
      rw = 9'd0;
      rf = 9'd0;
      qw = 9'd0;
      qf = 10'd0;
      bit_w = 1'b0;
      bit_f = 1'b0;
      for (int s = 0; s < DIV_STEPS; s++) begin
         rw = {cur.rem_w, cur.num_w[31]};
         bit_w = (rw >= {1'b0, ps});
         if (bit_w) rw = rw - {1'b0, ps};
         cur.rem_w = rw[7:0];
         cur.num_w = {cur.num_w[30:0], 1'b0};
         qw = {cur.q_w, bit_w};
         if (qw >= 9'(WHEEL_STEPS)) qw = qw - 9'(WHEEL_STEPS);
         cur.q_w = qw[7:0];

         rf = {cur.rem_f, cur.num_f[31]};
         bit_f = (rf >= {1'b0, fs});
         if (bit_f) rf = rf - {1'b0, fs};
         cur.rem_f = rf[7:0];
         cur.num_f = {cur.num_f[30:0], 1'b0};
         qf = {cur.q_f, bit_f};
         if (qf >= 10'(FADE_STEPS)) qf = qf - 10'(FADE_STEPS);
         cur.q_f = qf[8:0];
      end
      d_in_next = cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign d_out = d_ff;

endmodule

// ===== hdl/wcsg_serializer.sv =====
`include "assert_macros.svh"
module wcsg_serializer
   import wcsg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  inside_mode_type     inside_mode,
   input  logic                item_valid,
   input  logic [7:0]          item_base,
   input  logic [BRIGHT_W-1:0] item_bright,
   output logic                item_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // led_index, red, green, blue
   output logic                rsp_tlast    // last_led
);

   logic                busy_ff, busy_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [2:0]          col_ff, col_in;
   logic [1:0]          grp_ff, grp_in;
   logic [GCNT_W-1:0]   gcnt_ff, gcnt_in;
   logic [7:0]          base_ff, base_in;
   logic [BRIGHT_W-1:0] bright_ff, bright_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          led_ff, led_in;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;
   logic [7:0]          blue_ff, blue_in;
   logic                last_ff, last_in;

   logic       load;
   logic       emit;
   logic       at_last;
   logic [7:0] led_off;
   logic [7:0] pos;
   logic [8:0] pos_sum;
   logic [7:0] wr, wg, wb;
   logic [7:0] q;
   logic [24:0] pr, pg, pb;

   assign load    = !rsp_valid_ff || rsp_tready;
   assign emit    = busy_ff && load;
   assign at_last = (idx_ff == IDX_W'(LAST_LED));
   assign item_ready = !busy_ff || (load && at_last);

   always_comb begin
      case (inside_mode)
         STRIPE_CANDY:   led_off = idx_ff[0] ? STEP_HALF : 8'd0;
         STRIPE_HALF:    led_off = 8'(STEP_HALF * grp_ff);
         STRIPE_RAINBOW: led_off = 8'(STEP_SIXTH * col_ff);
         default:        led_off = 8'd0;
      endcase
      pos_sum = {1'b0, base_ff} + {1'b0, led_off};
      pos = pos_sum[7:0];
   end

   always_comb begin
      q = 8'd0;
      if (pos < 8'd85) begin
         wr = 8'(pos * 3);
         wg = 8'd255 - 8'(pos * 3);
         wb = 8'd0;
      end else if (pos < 8'd170) begin
         q = pos - 8'd85;
         wr = 8'd255 - 8'(q * 3);
         wg = 8'd0;
         wb = 8'(q * 3);
      end else begin
         q = pos - 8'd170;
         wr = 8'd0;
         wg = 8'(q * 3);
         wb = 8'd255 - 8'(q * 3);
      end
      pr = 25'(wr) * 25'(bright_ff);
      pg = 25'(wg) * 25'(bright_ff);
      pb = 25'(wb) * 25'(bright_ff);
   end

   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      col_in    = col_ff;
      grp_in    = grp_ff;
      gcnt_in   = gcnt_ff;
      base_in   = base_ff;
      bright_in = bright_ff;
      if (item_ready) begin
         busy_in   = item_valid;
         idx_in    = '0;
         col_in    = 3'd0;
         grp_in    = 2'd0;
         gcnt_in   = '0;
         base_in   = item_base;
         bright_in = item_bright;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
         col_in = (col_ff == 3'(RAINBOW_COLS - 1)) ? 3'd0 : col_ff + 3'd1;
         if (gcnt_ff == GCNT_W'(HALF_GROUP - 1)) begin
            gcnt_in = '0;
            grp_in = grp_ff + 2'd1;
         end else begin
            gcnt_in = gcnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      led_in   = led_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      last_in  = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         led_in   = 3'(idx_ff);
         red_in   = pr[23:16];
         green_in = pg[23:16];
         blue_in  = pb[23:16];
         last_in  = at_last;
      end else if (load) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         col_ff       <= 3'd0;
         grp_ff       <= 2'd0;
         gcnt_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         col_ff       <= col_in;
         grp_ff       <= grp_in;
         gcnt_ff      <= gcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      bright_ff <= bright_in;
      led_ff    <= led_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, blue_ff, green_ff, red_ff, led_ff};
   assign rsp_tlast  = last_ff;

   `ASSERT_ON(last_on_final_led, clock, reset, (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[2:0] == 3'(LAST_LED)))
   `ASSERT_NEVER(index_in_range, clock, reset, busy_ff && (idx_ff > IDX_W'(LAST_LED)))
   `ASSERT_ON(leds_follow_on, clock, reset, (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && (rsp_tdata[2:0] == 3'($past(rsp_tdata[2:0]) + 3'd1))))

endmodule

// ===== hdl/wheel_color_strip_generator_top.sv =====
// a request passes the 32-step divider, run as four 8-step pipeline stages, then
// ROM and brightness registers, then the one-colour-per-cycle output stage, which
// stalls while rsp_tready is low and takes the next request with the last colour
// reset: synchronous, active high; clears valid bits and restores register defaults
module wheel_color_strip_generator_top
   import wcsg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // local_time_ms, synced_time_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // led_index, red, green, blue
   output logic        rsp_tlast,   // last_led
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg;
   logic       en;
   logic       ser_ready;
   logic [7:0] ps_eff;
   logic [7:0] fs_eff;
   div_type    div_first;
   div_type    div_d [DIV_STAGES+1];
   logic       div_v [DIV_STAGES+1];

   logic                rom_valid_ff;
   logic [BRIGHT_W-1:0] fade_ff, fade_in;
   logic [BRIGHT_W-1:0] scale_ff, scale_in;
   logic [7:0]          base_ff, base_in;
   logic                bright_valid_ff;
   logic [BRIGHT_W-1:0] bright_ff, bright_in;
   logic [7:0]          base2_ff;
   logic [7:0]          offset;
   logic [15:0]         stag_prod;
   logic [8:0]          base_sum;
   logic [33:0]         bright_prod;

   wcsg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign en = !bright_valid_ff || ser_ready;
   assign req_tready = en;
   assign ps_eff = (cfg.pattern_speed == 8'd0) ? 8'd1 : cfg.pattern_speed;
   assign fs_eff = (cfg.fade_speed == 8'd0) ? 8'd1 : cfg.fade_speed;

   always_comb begin
      div_first.num_w = (cfg.timing_mode == TIMING_LOCAL) ? req_tdata[31:0] : req_tdata[63:32];
      div_first.num_f = cfg.fade_synced ? req_tdata[63:32] : req_tdata[31:0];
      div_first.rem_w = 8'd0;
      div_first.rem_f = 8'd0;
      div_first.q_w   = 8'd0;
      div_first.q_f   = 9'd0;
   end

   assign div_d[0] = div_first;
   assign div_v[0] = req_tvalid;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      wcsg_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (div_v[g]),
         .d_in      (div_d[g]),
         .ps        (ps_eff),
         .fs        (fs_eff),
         .valid_out (div_v[g+1]),
         .d_out     (div_d[g+1])
      );
   end

   always_comb begin
      stag_prod = cfg.own_address * STEP_ROM[cfg.node_count][7:0];
      case (cfg.timing_mode)
         TIMING_STAGGERED: offset = stag_prod[7:0];
         TIMING_ALTERNATE: offset = cfg.own_address[0] ? 8'd0 : 8'd128;
         default:          offset = 8'd0;
      endcase
      base_sum = {1'b0, div_d[DIV_STAGES].q_w} + {1'b0, offset};
      base_in  = base_sum[7:0];
      fade_in  = (cfg.fade_speed == 8'd0) ? BRIGHT_ONE : FADE_ROM[div_d[DIV_STAGES].q_f];
      scale_in = SCALE_ROM[cfg.brightness_scale];
   end

   assign bright_prod = 34'(fade_ff) * 34'(scale_ff);
   assign bright_in   = bright_prod[32:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_valid_ff    <= 1'b0;
         bright_valid_ff <= 1'b0;
      end else if (en) begin
         rom_valid_ff    <= div_v[DIV_STAGES];
         bright_valid_ff <= rom_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fade_ff   <= fade_in;
         scale_ff  <= scale_in;
         base_ff   <= base_in;
         bright_ff <= bright_in;
         base2_ff  <= base_ff;
      end
   end

   wcsg_serializer u_ser (
      .clock       (clock),
      .reset       (reset),
      .inside_mode (cfg.inside_mode),
      .item_valid  (bright_valid_ff),
      .item_base   (base2_ff),
      .item_bright (bright_ff),
      .item_ready  (ser_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== tb/wheel_color_strip_generator_top_tb.sv =====
module wheel_color_strip_generator_top_tb;
   import wcsg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0] led;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } colour_type;

   typedef struct {
      logic [31:0] local_ms;
      logic [31:0] synced_ms;
      bit          typed;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } tick_row_type;

   typedef enum {RX_OPEN, RX_COIN, RX_RHYTHM, RX_SPARSE} rx_style_type;

   localparam int PHASES     = 16;
   localparam int PER_PHASE  = 25;
   localparam int DRAIN_WAIT = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   colour_type   colour_q[$];
   cfg_type      model_cfg;
   int           fail_count = 0;
   int           burst_left = 0;
   int           rx_count = 0;
   rx_style_type rx_style = RX_OPEN;

   wheel_color_strip_generator_top DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // fade level for table index i, 16 fraction bits
   function automatic int unsigned cosine_fade(int unsigned i);
      longint unsigned pi_q = 64'd3373259426;
      longint unsigned one_q = 64'd1073741824;
      longint unsigned ang;
      longint unsigned red_ang;
      longint unsigned sq;
      longint unsigned term;
      longint          acc;
      bit              flip;
      ang = (longint'(i) << 30) / 50;
      if (ang > pi_q) ang = 2 * pi_q - ang;
      flip = ang > (pi_q >> 1);
      red_ang = flip ? pi_q - ang : ang;
      sq = (red_ang * red_ang) >> 30;
      term = one_q;
      acc = longint'(one_q);
      for (int k = 1; k <= 10; k++) begin
         term = ((term * sq) >> 30) / longint'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc > longint'(one_q)) acc = longint'(one_q);
      if (acc < 0) acc = 0;
      if (flip) acc = -acc;
      return int'((2 * acc + 3 * longint'(one_q)) / 81920);
   endfunction

   function automatic logic [7:0] wheel_level(int unsigned p, int ch);
      int unsigned q;
      if (p < 85) begin
         return (ch == 0) ? 8'(3 * p) : (ch == 1) ? 8'(255 - 3 * p) : 8'd0;
      end else if (p < 170) begin
         q = p - 85;
         return (ch == 0) ? 8'(255 - 3 * q) : (ch == 1) ? 8'd0 : 8'(3 * q);
      end
      q = p - 170;
      return (ch == 0) ? 8'd0 : (ch == 1) ? 8'(3 * q) : 8'(255 - 3 * q);
   endfunction

   task automatic predict_strip(logic [31:0] local_ms, logic [31:0] synced_ms);
      int unsigned t;
      int unsigned spd;
      int unsigned nodes;
      int unsigned scale;
      int unsigned fade;
      int unsigned bright;
      int unsigned pos;
      int unsigned offs;
      int unsigned base;
      int unsigned ncol;
      int unsigned stride;
      int unsigned grp;
      int unsigned p;
      int unsigned fspd;
      int unsigned ft;
      colour_type  c;
      t = (model_cfg.timing_mode == TIMING_LOCAL) ? local_ms : synced_ms;
      spd = model_cfg.pattern_speed ? model_cfg.pattern_speed : 1;
      nodes = model_cfg.node_count ? model_cfg.node_count : 1;
      scale = ((200 + model_cfg.brightness_scale * 800 / 255) * 65536) / 1000;
      fspd = model_cfg.fade_speed;
      if (fspd == 0) begin
         fade = 65536;
      end else begin
         ft = model_cfg.fade_synced ? synced_ms : local_ms;
         fade = cosine_fade((ft % (314 * fspd)) / fspd);
      end
      bright = int'((longint'(scale) * fade) >> 16);
      pos = int'((longint'(t) % (256 * spd)) / spd);
      offs = 0;
      if (model_cfg.timing_mode == TIMING_STAGGERED)
         offs = (model_cfg.own_address * (256 / nodes)) & 8'hFF;
      else if (model_cfg.timing_mode == TIMING_ALTERNATE && !model_cfg.own_address[0])
         offs = 128;
      base = (pos + offs) & 8'hFF;
      ncol = (model_cfg.inside_mode == STRIPE_SOLID) ? 1 :
             (model_cfg.inside_mode == STRIPE_RAINBOW) ? 6 : 2;
      stride = (256 / ncol) & 8'hFF;
      grp = (6 / ncol) ? 6 / ncol : 1;
      for (int i = 0; i < 6; i++) begin
         p = base;
         if (ncol > 1) begin
            if (model_cfg.inside_mode == STRIPE_HALF) p += stride * (i / grp);
            else p += stride * (i % ncol);
            p &= 8'hFF;
         end
         c.led = 3'(i);
         c.red = 8'((wheel_level(p, 0) * bright) >> 16);
         c.green = 8'((wheel_level(p, 1) * bright) >> 16);
         c.blue = 8'((wheel_level(p, 2) * bright) >> 16);
         c.last = (i == 5);
         colour_q.push_back(c);
      end
   endtask

   // called at a rising edge; returns at the take or after an idle gap
   task automatic send_tick(logic [31:0] local_ms, logic [31:0] synced_ms,
                            bit typed = 1'b0, logic [7:0] red = 8'd0,
                            logic [7:0] green = 8'd0, logic [7:0] blue = 8'd0);
      req_tvalid <= 1'b1;
      req_tdata <= {synced_ms, local_ms};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      predict_strip(local_ms, synced_ms);
      if (typed) begin
         for (int k = colour_q.size() - LED_COUNT; k < colour_q.size(); k++) begin
            colour_q[k].red = red;
            colour_q[k].green = green;
            colour_q[k].blue = blue;
         end
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end
   endtask

   task automatic write_reg(reg_index_type idx, logic [7:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(4 * idx);
      csr_pwdata <= {24'($urandom), v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_PATTERN_SPEED: model_cfg.pattern_speed = v;
         REG_FADE_SPEED:    model_cfg.fade_speed = v;
         REG_FADE_SYNCED:   model_cfg.fade_synced = v[0];
         REG_BRIGHTNESS:    model_cfg.brightness_scale = v;
         REG_TIMING_MODE:   model_cfg.timing_mode = timing_mode_type'(v[1:0]);
         REG_INSIDE_MODE:   model_cfg.inside_mode = inside_mode_type'(v[1:0]);
         REG_OWN_ADDRESS:   model_cfg.own_address = v;
         REG_NODE_COUNT:    model_cfg.node_count = v;
         default: ;
      endcase
   endtask

   task automatic apply_settings(cfg_type c);
      req_tvalid <= 1'b0;
      while (colour_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      write_reg(REG_PATTERN_SPEED, c.pattern_speed);
      write_reg(REG_FADE_SPEED, c.fade_speed);
      write_reg(REG_FADE_SYNCED, {7'($urandom), c.fade_synced});
      write_reg(REG_BRIGHTNESS, c.brightness_scale);
      write_reg(REG_TIMING_MODE, {6'($urandom), c.timing_mode});
      write_reg(REG_INSIDE_MODE, {6'($urandom), c.inside_mode});
      write_reg(REG_OWN_ADDRESS, c.own_address);
      write_reg(REG_NODE_COUNT, c.node_count);
   endtask

   function automatic logic [31:0] random_ms();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 70000);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 70000);
         default: return $urandom;
      endcase
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      rx_count <= rx_count + 1;
      if (rx_count % 97 == 0) rx_style <= rx_style_type'($urandom_range(0, 3));
      case (rx_style)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= $urandom_range(0, 1);
         RX_RHYTHM: rsp_tready <= (rx_count % 5) < 3;
         default:   rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // colour checker
   always @(negedge clock) begin
      colour_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (colour_q.size() == 0) begin
            $display("%0t unexpected colour: expected none, actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = colour_q.pop_front();
            if (rsp_tdata[2:0] !== want.led || rsp_tdata[10:3] !== want.red ||
                rsp_tdata[18:11] !== want.green || rsp_tdata[26:19] !== want.blue ||
                rsp_tlast !== want.last) begin
               $display("%0t colour mismatch: expected led %0d rgb %0d %0d %0d last %b,",
                        $time, want.led, want.red, want.green, want.blue, want.last);
               $display("   actual led %0d rgb %0d %0d %0d last %b", rsp_tdata[2:0],
                        rsp_tdata[10:3], rsp_tdata[18:11], rsp_tdata[26:19], rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      tick_row_type ticks[] = '{
         '{32'h0, 32'h0, 1'b1, 8'd0, 8'd255, 8'd0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 8'd0, 8'd0, 8'd0},
         '{32'h0, 32'hFFFF_FFFF, 1'b0, 8'd0, 8'd0, 8'd0},
         '{32'hFFFF_FFFF, 32'h0, 1'b1, 8'd0, 8'd255, 8'd0},
         '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 8'd0, 8'd0, 8'd0},
         '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 8'd0, 8'd0, 8'd0},
         '{32'd0, 32'd3570, 1'b0, 8'd0, 8'd0, 8'd0},
         '{32'd0, 32'd10751, 1'b0, 8'd0, 8'd0, 8'd0}
      };
      cfg_type presets[4] = '{
         '{8'd0, 8'd1, 1'b1, 8'd0, TIMING_STAGGERED, STRIPE_CANDY, 8'd255, 8'd0},
         '{8'd255, 8'd255, 1'b0, 8'd255, TIMING_ALTERNATE, STRIPE_HALF, 8'd0, 8'd255},
         '{8'd1, 8'd0, 1'b0, 8'd128, TIMING_LOCAL, STRIPE_RAINBOW, 8'd7, 8'd1},
         '{8'd1, 8'd1, 1'b1, 8'd255, TIMING_ALTERNATE, STRIPE_RAINBOW, 8'd1, 8'd3}
      };
      cfg_type c;
      model_cfg = '{8'd42, 8'd0, 1'b0, 8'd255, TIMING_SYNCED, STRIPE_SOLID, 8'd0, 8'd1};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (ticks[n]) begin
         send_tick(ticks[n].local_ms, ticks[n].synced_ms, ticks[n].typed,
                   ticks[n].red, ticks[n].green, ticks[n].blue);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 4) begin
            c = presets[ph];
         end else begin
            c.pattern_speed = $urandom_range(0, 3) ? $urandom_range(1, 16) : $urandom;
            c.fade_speed = $urandom_range(0, 2) ? $urandom_range(0, 20) : $urandom;
            c.fade_synced = $urandom;
            c.brightness_scale = $urandom;
            c.timing_mode = timing_mode_type'($urandom_range(0, 3));
            c.inside_mode = inside_mode_type'($urandom_range(0, 3));
            c.own_address = $urandom;
            c.node_count = $urandom;
         end
         apply_settings(c);
         @(posedge clock);
         for (int n = 0; n < PER_PHASE; n++) send_tick(random_ms(), random_ms());
         req_tvalid <= 1'b0;
      end

      while (colour_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
